// ===== hw/rtl/cdn_pkg.sv =====
// Shared constants and the month offset table for the calendar day number converter.
// Depends on nothing; the control, datapath and top files import it.
package cdn_pkg;

	// Number of register stages from input transaction to result.
	localparam int Stages = 7;

	localparam logic CmdDateToNum = 1'b0;
	localparam logic CmdNumToDate = 1'b1;

	localparam logic [13:0] MaxYear      = 14'd9999;
	localparam logic [21:0] MaxDayNumber = 22'd3652059;

	// Days from March 1 to the first of a March-based month (3 is March, 14 is February).
	function automatic logic [8:0] month_start(input logic [3:0] mar_month);
		logic [8:0] offs;
		case (mar_month)
			4'd3:    offs = 9'd0;
			4'd4:    offs = 9'd31;
			4'd5:    offs = 9'd61;
			4'd6:    offs = 9'd92;
			4'd7:    offs = 9'd122;
			4'd8:    offs = 9'd153;
			4'd9:    offs = 9'd184;
			4'd10:   offs = 9'd214;
			4'd11:   offs = 9'd245;
			4'd12:   offs = 9'd275;
			4'd13:   offs = 9'd306;
			4'd14:   offs = 9'd337;
			default: offs = 9'd0;
		endcase
		return offs;
	endfunction

endpackage

// ===== hw/rtl/cdn_in_if.sv =====
// Input channel of the calendar day number converter: valid, ready and one request.
// Depends on nothing.
interface cdn_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [13:0] in_year;
	logic [3:0]  in_month;
	logic [4:0]  in_day;
	logic [21:0] in_day_number;

	modport source (output valid, cmd, in_year, in_month, in_day, in_day_number, input ready);
	modport sink (input valid, cmd, in_year, in_month, in_day, in_day_number, output ready);
endinterface

// ===== hw/rtl/cdn_out_if.sv =====
// Output channel of the calendar day number converter: valid, ready and one result.
// Depends on nothing.
interface cdn_out_if;
	logic        valid;
	logic        ready;
	logic [21:0] out_day_number;
	logic [13:0] out_year;
	logic [3:0]  out_month;
	logic [4:0]  out_day;
	logic        bad_input;

	modport source (output valid, out_day_number, out_year, out_month, out_day, bad_input,
		input ready);
	modport sink (input valid, out_day_number, out_year, out_month, out_day, bad_input,
		output ready);
endinterface

// ===== hw/rtl/cdn_ctrl.sv =====
// Pipeline control: per-stage valid bits and load enables with stall backpressure.
// Depends on cdn_pkg.
module cdn_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [cdn_pkg::Stages:1] en
);
	import cdn_pkg::*;

	logic [Stages:1] stage_vld_q;
	logic [Stages:1] vld_next;

	// A stage loads when it is empty or when its content moves on in the same cycle.
	always_comb begin
		en[Stages] = !stage_vld_q[Stages] || out_ready;
		for (int k = Stages - 1; k >= 1; k--) begin
			en[k] = !stage_vld_q[k] || en[k + 1];
		end
	end

	assign vld_next  = {stage_vld_q[Stages-1:1], in_valid};
	assign in_ready  = en[1];
	assign out_valid = stage_vld_q[Stages];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			for (int k = 1; k <= Stages; k++) begin
				if (en[k]) begin
					stage_vld_q[k] <= vld_next[k];
				end
			end
		end
	end
endmodule

// ===== hw/rtl/cdn_fwd.sv =====
// Date to day number datapath: range check, March-based month shift, year terms, sum.
// Depends on cdn_pkg for the month offset table and limits.
module cdn_fwd (
	input  logic                     clk,
	input  logic [cdn_pkg::Stages:1] en,
	input  logic                     cmd,
	input  logic [13:0]              in_year,
	input  logic [3:0]               in_month,
	input  logic [4:0]               in_day,
	output logic [21:0]              day_number,
	output logic                     bad
);
	import cdn_pkg::*;

	logic        ok;
	logic [13:0] y_adj;
	logic [3:0]  m_adj;

	logic        go_s1, bad_s1;
	logic [13:0] y_s1;
	logic [8:0]  offs_s1;
	logic [4:0]  day_s1;

	logic        go_s2, bad_s2;
	logic [13:0] y_s2;
	logic [8:0]  offs_s2;
	logic [4:0]  day_s2;
	logic [26:0] p100_s2;
	logic [22:0] y365_s2;

	logic [6:0]  c100;
	logic [22:0] sum;

	logic [21:0] dn_s3, dn_s4, dn_s5, dn_s6, dn_s7;
	logic        bad_s3, bad_s4, bad_s5, bad_s6, bad_s7;

	assign ok = (cmd == CmdDateToNum) && (in_year >= 14'd1) && (in_year <= MaxYear)
		&& (in_month >= 4'd1) && (in_month <= 4'd12) && (in_day >= 5'd1);

	// January and February count as months 13 and 14 of the previous year.
	assign y_adj = (in_month < 4'd3) ? in_year - 14'd1 : in_year;
	assign m_adj = (in_month < 4'd3) ? in_month + 4'd12 : in_month;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			go_s1   <= ok;
			bad_s1  <= (cmd == CmdDateToNum) && !ok;
			y_s1    <= y_adj;
			offs_s1 <= month_start(m_adj);
			day_s1  <= in_day;
		end
	end

	// The product by 5243 shifted right by 19 is the year divided by 100 for years below 10000.
	always_ff @(posedge clk) begin
		if (en[2]) begin
			go_s2   <= go_s1;
			bad_s2  <= bad_s1;
			y_s2    <= y_s1;
			offs_s2 <= offs_s1;
			day_s2  <= day_s1;
			p100_s2 <= 27'(y_s1) * 27'd5243;
			y365_s2 <= 23'(y_s1) * 23'd365;
		end
	end

	assign c100 = p100_s2[25:19];
	assign sum  = y365_s2 + 23'(y_s2[13:2]) - 23'(c100) + 23'(c100[6:2])
		+ 23'(offs_s2) + 23'(day_s2) - 23'd306;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			dn_s3  <= go_s2 ? sum[21:0] : 22'd0;
			bad_s3 <= bad_s2;
		end
		if (en[4]) begin
			dn_s4  <= dn_s3;
			bad_s4 <= bad_s3;
		end
		if (en[5]) begin
			dn_s5  <= dn_s4;
			bad_s5 <= bad_s4;
		end
		if (en[6]) begin
			dn_s6  <= dn_s5;
			bad_s6 <= bad_s5;
		end
		if (en[7]) begin
			dn_s7  <= dn_s6;
			bad_s7 <= bad_s6;
		end
	end

	assign day_number = dn_s7;
	assign bad        = bad_s7;
endmodule

// ===== hw/rtl/cdn_inv.sv =====
// Day number to date datapath: quarter-day century and year divisions by reciprocal
// multiply with one correction step each, then month and day recovery. Depends on cdn_pkg.
module cdn_inv (
	input  logic                     clk,
	input  logic [cdn_pkg::Stages:1] en,
	input  logic                     cmd,
	input  logic [21:0]              in_day_number,
	output logic [13:0]              year,
	output logic [3:0]               month,
	output logic [4:0]               day,
	output logic                     bad
);
	import cdn_pkg::*;

	logic        ok;
	logic [21:0] z;

	logic        go_s1, go_s2, go_s3, go_s4, go_s5, go_s6;
	logic        bad_s1, bad_s2, bad_s3, bad_s4, bad_s5, bad_s6, bad_s7;
	logic [21:0] z_s1, z_s2, z_s3, z_s4, z_s5;
	logic [23:0] x_s1, x_s2, x_s3;
	logic [6:0]  ea_s2, a_s3, a_s4, a_s5;

	logic [30:0] pe_a;
	logic [24:0] pa, rem_a;
	logic [6:0]  a_fix;

	logic [24:0] b4;
	logic [38:0] pe_y;
	logic [13:0] ey_s4;
	logic [24:0] b4_s4;

	logic [24:0] py, rem_y;
	logic [13:0] y_s5, y_s6;
	logic [24:0] t_s5;

	logic [24:0] c_full;
	logic [19:0] mp;
	logic [9:0]  c_s6;
	logic [3:0]  m_s6;

	logic [9:0]  dd;
	logic [13:0] year_s7;
	logic [3:0]  month_s7;
	logic [4:0]  day_s7;

	assign ok = (cmd == CmdNumToDate) && (in_day_number >= 22'd1)
		&& (in_day_number <= MaxDayNumber);
	assign z  = in_day_number + 22'd306;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			go_s1  <= ok;
			bad_s1 <= (cmd == CmdNumToDate) && !ok;
			z_s1   <= z;
			x_s1   <= {z, 2'b00} - 24'd1;
		end
	end

	// Estimate of the quarter-day count over 146097, low by at most one.
	assign pe_a = 31'(x_s1) * 31'd114;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			go_s2  <= go_s1;
			bad_s2 <= bad_s1;
			z_s2   <= z_s1;
			x_s2   <= x_s1;
			ea_s2  <= pe_a[30:24];
		end
	end

	assign pa    = 25'(ea_s2) * 25'd146097;
	assign rem_a = {1'b0, x_s2} - pa;
	assign a_fix = (rem_a >= 25'd146097) ? ea_s2 + 7'd1 : ea_s2;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			go_s3  <= go_s2;
			bad_s3 <= bad_s2;
			z_s3   <= z_s2;
			x_s3   <= x_s2;
			a_s3   <= a_fix;
		end
	end

	// Add back the skipped leap days of the centuries, then estimate the years over 1461.
	assign b4   = {1'b0, x_s3} + 25'({a_s3 - {2'b00, a_s3[6:2]}, 2'b00});
	assign pe_y = 39'(b4) * 39'd11483;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			go_s4  <= go_s3;
			bad_s4 <= bad_s3;
			z_s4   <= z_s3;
			a_s4   <= a_s3;
			b4_s4  <= b4;
			ey_s4  <= pe_y[37:24];
		end
	end

	assign py    = 25'(ey_s4) * 25'd1461;
	assign rem_y = b4_s4 - py;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			go_s5  <= go_s4;
			bad_s5 <= bad_s4;
			z_s5   <= z_s4;
			a_s5   <= a_s4;
			if (rem_y >= 25'd1461) begin
				y_s5 <= ey_s4 + 14'd1;
				t_s5 <= py + 25'd1461;
			end else begin
				y_s5 <= ey_s4;
				t_s5 <= py;
			end
		end
	end

	// Day of the March-based year, then its month.
	assign c_full = 25'(z_s5) + 25'(a_s5) - 25'(a_s5[6:2]) - 25'(t_s5[24:2]);
	assign mp     = 20'(c_full[9:0]) * 20'd535 + 20'd48950;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			go_s6  <= go_s5;
			bad_s6 <= bad_s5;
			y_s6   <= y_s5;
			c_s6   <= c_full[9:0];
			m_s6   <= mp[17:14];
		end
	end

	assign dd = c_s6 - 10'(month_start(m_s6));

	always_ff @(posedge clk) begin
		if (en[7]) begin
			bad_s7 <= bad_s6;
			if (!go_s6) begin
				year_s7  <= 14'd0;
				month_s7 <= 4'd0;
				day_s7   <= 5'd0;
			end else if (m_s6 > 4'd12) begin
				year_s7  <= y_s6 + 14'd1;
				month_s7 <= m_s6 - 4'd12;
				day_s7   <= dd[4:0];
			end else begin
				year_s7  <= y_s6;
				month_s7 <= m_s6;
				day_s7   <= dd[4:0];
			end
		end
	end

	assign year  = year_s7;
	assign month = month_s7;
	assign day   = day_s7;
	assign bad   = bad_s7;
endmodule

// ===== hw/rtl/calendar_day_number_converter.sv =====
// Converts between a proleptic Gregorian date and its Rata Die day number (day 1 is
// 0001-01-01); cmd 0 maps a date to a number, cmd 1 maps a number to a date. The block
// takes one transaction per clock cycle while its output is not stalled and returns
// each result from the last stage of its seven-stage pipeline, whose stages are paced by
// the two reciprocal-multiply divisions with correction in the number-to-date path. A
// stalled output holds the pipeline in place; empty stages keep filling, so requests
// are still taken while a result waits. Inputs outside range give bad_input and zeros.
// Depends on cdn_pkg, cdn_in_if, cdn_out_if, cdn_ctrl, cdn_fwd and cdn_inv.
module calendar_day_number_converter (
	input  logic      clk,
	input  logic      arst_n,
	cdn_in_if.sink    req,
	cdn_out_if.source rsp
);
	import cdn_pkg::*;

	logic [Stages:1] en;
	logic [21:0]     fwd_day_number;
	logic            fwd_bad;
	logic [13:0]     inv_year;
	logic [3:0]      inv_month;
	logic [4:0]      inv_day;
	logic            inv_bad;

	cdn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.en        (en)
	);

	cdn_fwd u_fwd (
		.clk        (clk),
		.en         (en),
		.cmd        (req.cmd),
		.in_year    (req.in_year),
		.in_month   (req.in_month),
		.in_day     (req.in_day),
		.day_number (fwd_day_number),
		.bad        (fwd_bad)
	);

	cdn_inv u_inv (
		.clk           (clk),
		.en            (en),
		.cmd           (req.cmd),
		.in_day_number (req.in_day_number),
		.year          (inv_year),
		.month         (inv_month),
		.day           (inv_day),
		.bad           (inv_bad)
	);

	// Each path zeroes its fields and flag unless the transaction chose its mode.
	assign rsp.out_day_number = fwd_day_number;
	assign rsp.out_year       = inv_year;
	assign rsp.out_month      = inv_month;
	assign rsp.out_day        = inv_day;
	assign rsp.bad_input      = fwd_bad | inv_bad;
endmodule
